>>> rtl/srrw_pkg.sv
package srrw_pkg;

	// Field widths fixed by the segment and result formats.
	localparam int SEQ_W    = 15;
	localparam int LEN_W    = 10;
	localparam int FHDL_W   = 16;
	localparam int CMD_W    = 2;
	localparam int KIND_W   = 2;
	// Width of the modulo reduction register: holds seq + length and SEQ_MOD itself.
	localparam int RED_W    = 17;

	// Default configuration of the window.
	localparam int WINDOW_DEF      = 10;
	localparam int SEQ_MOD_DEF     = 25601;
	localparam int SEG_STRIDE_DEF  = 512;
	localparam int HANDLE_BITS_DEF = 16;

	// Register file.
	localparam int ADDR_W = 3;
	localparam logic REG_START_BASE = 1'b0;
	localparam logic REG_OWN_SEQ    = 1'b1;

	// Segment commands.
	localparam logic [CMD_W-1:0] CMD_OPEN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIN  = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DUP_ACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIN_ACK = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SEQ_W-1:0]  seg_seq;
		logic [LEN_W-1:0]  seg_length;
		logic [FHDL_W-1:0] payload_handle;
	} seg_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  hdr_seq;
		logic [SEQ_W-1:0]  hdr_ack;
		logic [FHDL_W-1:0] out_handle;
		logic [LEN_W-1:0]  out_length;
		logic              last;
	} res_beat_t;

	// Commands broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic load;
		logic shift;
		logic write;
	} chain_ctl_t;

	// Match status rippling from the bottom cell upwards.
	typedef struct packed {
		logic hit;
		logic dup;
		logic prev_hit;
	} chain_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_REDUCE,
		ST_DECIDE,
		ST_DELIVER
	} state_t;

endpackage

>>> rtl/srrw_cell.sv
module srrw_cell #(
	parameter int SEQ_MOD   = srrw_pkg::SEQ_MOD_DEF,
	parameter int PW        = 15,
	parameter int HB        = srrw_pkg::HANDLE_BITS_DEF,
	parameter int OFFSET    = 0,
	parameter int PREV_BACK = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srrw_pkg::chain_ctl_t        ctl,
	input  logic [PW-1:0]               base,
	input  logic [srrw_pkg::SEQ_W-1:0]  seq,
	input  logic [srrw_pkg::LEN_W-1:0]  wr_len,
	input  logic [HB-1:0]               wr_hdl,
	input  logic [PW-1:0]               nxt_pos,
	input  logic                        nxt_valid,
	input  logic [srrw_pkg::LEN_W-1:0]  nxt_len,
	input  logic [HB-1:0]               nxt_hdl,
	input  srrw_pkg::chain_stat_t       stat_in,
	output srrw_pkg::chain_stat_t       stat_out,
	output logic [PW-1:0]               pos,
	output logic                        valid,
	output logic [srrw_pkg::LEN_W-1:0]  len,
	output logic [HB-1:0]               hdl
);
	import srrw_pkg::*;

	logic [PW-1:0]    pos_q;
	logic             valid_q;
	logic [LEN_W-1:0] len_q;
	logic [HB-1:0]    hdl_q;
	logic [PW:0]      load_sum;
	logic [PW-1:0]    load_pos;
	logic [PW:0]      prev_sum;
	logic [PW-1:0]    prev_pos;
	logic             match;
	logic             prev_match;
	logic             first;

	// Position of this slot after an open: base plus a fixed offset, wrapped once.
	always_comb begin
		load_sum = {1'b0, base} + (PW+1)'(OFFSET);
		if (load_sum >= (PW+1)'(SEQ_MOD)) begin
			load_sum = load_sum - (PW+1)'(SEQ_MOD);
		end
		load_pos = load_sum[PW-1:0];
	end

	// The matching slot of the previous window lies a whole window below this one.
	always_comb begin
		prev_sum = {1'b0, pos_q} + (PW+1)'(SEQ_MOD - PREV_BACK);
		if (prev_sum >= (PW+1)'(SEQ_MOD)) begin
			prev_sum = prev_sum - (PW+1)'(SEQ_MOD);
		end
		prev_pos = prev_sum[PW-1:0];
	end

	assign match      = RED_W'(pos_q) == RED_W'(seq);
	assign prev_match = RED_W'(prev_pos) == RED_W'(seq);
	assign first      = match && !stat_in.hit;

	assign stat_out.hit      = stat_in.hit || match;
	assign stat_out.dup      = stat_in.dup || (first && valid_q);
	assign stat_out.prev_hit = stat_in.prev_hit || prev_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= PW'(OFFSET);
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			pos_q   <= load_pos;
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			pos_q   <= nxt_pos;
			valid_q <= nxt_valid;
		end else if (ctl.write && first) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			len_q <= nxt_len;
			hdl_q <= nxt_hdl;
		end else if (ctl.write && first) begin
			len_q <= wr_len;
			hdl_q <= wr_hdl;
		end
	end

	assign pos   = pos_q;
	assign valid = valid_q;
	assign len   = len_q;
	assign hdl   = hdl_q;

endmodule

>>> rtl/srrw_ctrl.sv
module srrw_ctrl #(
	parameter int SEQ_MOD = srrw_pkg::SEQ_MOD_DEF,
	parameter int PW      = 15,
	parameter int HB      = srrw_pkg::HANDLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seg_valid,
	output logic                        seg_stall,
	input  srrw_pkg::seg_beat_t         seg,
	output logic                        res_valid,
	input  logic                        res_stall,
	output srrw_pkg::res_beat_t         res,
	input  logic [srrw_pkg::SEQ_W-1:0]  start_base,
	input  logic [srrw_pkg::SEQ_W-1:0]  own_seq,
	output srrw_pkg::chain_ctl_t        ctl,
	input  srrw_pkg::chain_stat_t       stat,
	input  logic                        v0,
	input  logic                        v1,
	input  logic                        m0,
	input  logic [srrw_pkg::LEN_W-1:0]  len0,
	input  logic [HB-1:0]               hdl0,
	output logic [PW-1:0]               base,
	output logic [srrw_pkg::SEQ_W-1:0]  seq,
	output logic [srrw_pkg::LEN_W-1:0]  wr_len,
	output logic [HB-1:0]               wr_hdl
);
	import srrw_pkg::*;

	state_t           state_q, state_d;
	logic             closed_q;
	logic             set_closed, clr_closed;
	logic [CMD_W-1:0] cmd_q;
	logic [SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0] len_q;
	logic [HB-1:0]    hdl_q;
	logic [RED_W-1:0] red_q;
	logic             red_ge;
	logic             accept;
	logic             out_free;
	logic             emit;
	res_beat_t        emit_beat;
	logic             res_valid_q;
	res_beat_t        res_q;

	assign accept   = seg_valid && !seg_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign red_ge   = red_q >= RED_W'(SEQ_MOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			closed_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (set_closed) begin
				closed_q <= 1'b1;
			end else if (clr_closed) begin
				closed_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		seg_stall  = 1'b1;
		set_closed = 1'b0;
		clr_closed = 1'b0;
		ctl        = '0;
		emit       = 1'b0;
		emit_beat  = '0;
		emit_beat.hdr_seq = own_seq;
		emit_beat.hdr_ack = red_q[SEQ_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				seg_stall = 1'b0;
				if (seg_valid) begin
					unique case (seg.cmd)
						CMD_OPEN: state_d = ST_OPEN;
						CMD_FIN: begin
							set_closed = 1'b1;
							state_d    = ST_REDUCE;
						end
						CMD_DATA: begin
							if (!closed_q) begin
								state_d = ST_REDUCE;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_OPEN: begin
				if (!red_ge) begin
					ctl.load   = 1'b1;
					clr_closed = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_REDUCE: begin
				if (!red_ge) begin
					if (cmd_q == CMD_FIN) begin
						if (out_free) begin
							emit           = 1'b1;
							emit_beat.kind = KIND_FIN_ACK;
							emit_beat.last = 1'b1;
							state_d        = ST_IDLE;
						end
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (stat.hit && !stat.dup) begin
					if (out_free) begin
						ctl.write      = 1'b1;
						emit           = 1'b1;
						emit_beat.kind = KIND_ACK;
						emit_beat.last = !(v0 || m0);
						state_d        = (v0 || m0) ? ST_DELIVER : ST_IDLE;
					end
				end else if (stat.hit || stat.prev_hit) begin
					if (out_free) begin
						emit           = 1'b1;
						emit_beat.kind = KIND_DUP_ACK;
						emit_beat.last = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					ctl.shift            = 1'b1;
					emit                 = 1'b1;
					emit_beat.kind       = KIND_DELIVER;
					emit_beat.hdr_seq    = '0;
					emit_beat.hdr_ack    = '0;
					emit_beat.out_handle = FHDL_W'(hdl0);
					emit_beat.out_length = len0;
					emit_beat.last       = !v1;
					state_d              = v1 ? ST_DELIVER : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Segment fields and the modulo reduction register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= seg.cmd;
			seq_q <= seg.seg_seq;
			len_q <= seg.seg_length;
			hdl_q <= HB'(seg.payload_handle);
			unique case (seg.cmd)
				CMD_OPEN: red_q <= RED_W'(start_base);
				CMD_FIN:  red_q <= RED_W'(seg.seg_seq) + RED_W'(1);
				default:  red_q <= RED_W'(seg.seg_seq) + RED_W'(seg.seg_length);
			endcase
		end else if ((state_q == ST_OPEN || state_q == ST_REDUCE) && red_ge) begin
			red_q <= red_q - RED_W'(SEQ_MOD);
		end
	end

	// Output register parting the sequencer from the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_beat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign base      = PW'(red_q);
	assign seq       = seq_q;
	assign wr_len    = len_q;
	assign wr_hdl    = hdl_q;

endmodule

>>> rtl/selective_repeat_receive_window.sv
// Channel   Beat type    Handshake              Direction
// seg       seg_beat_t   seg_valid / seg_stall  in: open, data and FIN segments
// res       res_beat_t   res_valid / res_stall  out: acks, FIN acks, deliveries
// apb       32-bit data  psel/penable/pready    in: start_base, own_seq
//
// One segment is handled at a time. An open, a FIN, or a data segment on an open
// connection first passes through the repeated-subtraction modulo loop; a data
// segment then takes the hit decision, and an ack may be followed by in-order
// deliveries. The delivery sequencer empties the bottom cell of the slot chain
// once per cycle while no stalled result is held in the output register.
// Reset clears the slot valid bits, sets the connection to closed and zeroes the
// configuration registers; no clearing pass is needed. A stalled result holds the
// sequencer only when a further result is ready to be written into the output register.
module selective_repeat_receive_window #(
	parameter int WINDOW      = srrw_pkg::WINDOW_DEF,
	parameter int SEQ_MOD     = srrw_pkg::SEQ_MOD_DEF,
	parameter int SEG_STRIDE  = srrw_pkg::SEG_STRIDE_DEF,
	parameter int HANDLE_BITS = srrw_pkg::HANDLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srrw_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         seg_valid,
	output logic                         seg_stall,
	input  srrw_pkg::seg_beat_t          seg,
	output logic                         res_valid,
	input  logic                         res_stall,
	output srrw_pkg::res_beat_t          res
);
	import srrw_pkg::*;

	// Width of a window position, which always lies below SEQ_MOD.
	localparam int PW         = $clog2(SEQ_MOD);
	localparam int STRIDE_RED = SEG_STRIDE % SEQ_MOD;
	localparam int PREV_BACK  = (WINDOW * SEG_STRIDE) % SEQ_MOD;

	logic [SEQ_W-1:0] start_base_q;
	logic [SEQ_W-1:0] own_seq_q;
	logic             cfg_wr;

	chain_ctl_t       ctl;
	chain_stat_t      stat [WINDOW+1];
	logic [PW-1:0]    pos_w [WINDOW];
	logic             valid_w [WINDOW];
	logic [LEN_W-1:0] len_w [WINDOW];
	logic [HANDLE_BITS-1:0] hdl_w [WINDOW];
	logic [PW-1:0]    base;
	logic [SEQ_W-1:0] seq;
	logic [LEN_W-1:0] wr_len;
	logic [HANDLE_BITS-1:0] wr_hdl;
	logic [PW:0]      top_sum;
	logic [PW-1:0]    top_pos_next;

	// Configuration registers. Word addresses; bit 2 picks the register.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_base_q <= '0;
			own_seq_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_START_BASE: start_base_q <= pwdata[SEQ_W-1:0];
				REG_OWN_SEQ:    own_seq_q    <= pwdata[SEQ_W-1:0];
				default:        start_base_q <= start_base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_START_BASE: prdata = 32'(start_base_q);
			REG_OWN_SEQ:    prdata = 32'(own_seq_q);
			default:        prdata = '0;
		endcase
	end

	// The top cell's position after a slide is its own position plus one stride.
	always_comb begin
		top_sum = {1'b0, pos_w[WINDOW-1]} + (PW+1)'(STRIDE_RED);
		if (top_sum >= (PW+1)'(SEQ_MOD)) begin
			top_sum = top_sum - (PW+1)'(SEQ_MOD);
		end
		top_pos_next = top_sum[PW-1:0];
	end

	assign stat[0] = '0;

	// Slot chain: cell 0 holds the receive base. On a slide every cell takes the
	// contents of the cell above it, and the top cell is refilled empty.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		localparam int OFFSET = (i * SEG_STRIDE) % SEQ_MOD;
		logic [PW-1:0]          nxt_pos;
		logic                   nxt_valid;
		logic [LEN_W-1:0]       nxt_len;
		logic [HANDLE_BITS-1:0] nxt_hdl;

		if (i == WINDOW - 1) begin : g_top
			assign nxt_pos   = top_pos_next;
			assign nxt_valid = 1'b0;
			assign nxt_len   = '0;
			assign nxt_hdl   = '0;
		end else begin : g_mid
			assign nxt_pos   = pos_w[i+1];
			assign nxt_valid = valid_w[i+1];
			assign nxt_len   = len_w[i+1];
			assign nxt_hdl   = hdl_w[i+1];
		end

		srrw_cell #(
			.SEQ_MOD   (SEQ_MOD),
			.PW        (PW),
			.HB        (HANDLE_BITS),
			.OFFSET    (OFFSET),
			.PREV_BACK (PREV_BACK)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.base      (base),
			.seq       (seq),
			.wr_len    (wr_len),
			.wr_hdl    (wr_hdl),
			.nxt_pos   (nxt_pos),
			.nxt_valid (nxt_valid),
			.nxt_len   (nxt_len),
			.nxt_hdl   (nxt_hdl),
			.stat_in   (stat[i]),
			.stat_out  (stat[i+1]),
			.pos       (pos_w[i]),
			.valid     (valid_w[i]),
			.len       (len_w[i]),
			.hdl       (hdl_w[i])
		);
	end

	// Sequencer: modulo reduction, hit decision, acks and in-order delivery.
	srrw_ctrl #(
		.SEQ_MOD (SEQ_MOD),
		.PW      (PW),
		.HB      (HANDLE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_valid),
		.seg_stall  (seg_stall),
		.seg        (seg),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.start_base (start_base_q),
		.own_seq    (own_seq_q),
		.ctl        (ctl),
		.stat       (stat[WINDOW]),
		.v0         (valid_w[0]),
		.v1         (valid_w[1]),
		.m0         (stat[1].hit),
		.len0       (len_w[0]),
		.hdl0       (hdl_w[0]),
		.base       (base),
		.seq        (seq),
		.wr_len     (wr_len),
		.wr_hdl     (wr_hdl)
	);

endmodule

>>> bench/selective_repeat_receive_window_tb.sv
`timescale 1ns / 1ps

module selective_repeat_receive_window_tb;

	import srrw_pkg::*;

	// The window geometry of the default build, used by the predictor.
	localparam int WIN    = WINDOW_DEF;
	localparam int MOD    = SEQ_MOD_DEF;
	localparam int STRIDE = SEG_STRIDE_DEF;

	// The fourth command encoding has no meaning and must be ignored by the block.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	// Time that the block may still spend on a segment that produces no result,
	// rounded well up from the worst case of its modulo loop.
	localparam int SETTLE_CYCLES  = 32;
	// Longest run of cycles without any beat, APB access or reset before giving up.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the deliberate result back-pressure stretch.
	localparam int HOLD_CYCLES    = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        seg_valid = 1'b0;
	logic        seg_stall;
	seg_beat_t   seg = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_beat_t   res;

	selective_repeat_receive_window DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predicted receiver state. It mirrors the window as the block should
	// hold it after every segment beat accepted so far, together with the
	// two configuration registers as last written over APB.
	// ------------------------------------------------------------------
	int unsigned       win_base = 0;
	bit                occupied [WIN];
	logic [LEN_W-1:0]  held_len [WIN];
	logic [FHDL_W-1:0] held_hdl [WIN];
	bit                conn_closed = 1'b1;
	logic [SEQ_W-1:0]  cfg_start_base = '0;
	logic [SEQ_W-1:0]  cfg_own_seq = '0;

	// Segments waiting to be offered, and the result beats that the accepted
	// segments still owe us, oldest first.
	seg_beat_t segment_queue [$];
	res_beat_t pending_replies [$];

	// Bookkeeping for the verdict and the closing summary.
	int mismatch_count = 0;
	int segs_accepted = 0;
	int replies_checked = 0;
	int deliveries_seen = 0;
	int dup_acks_seen = 0;
	int fin_acks_seen = 0;
	int input_blocked = 0;
	int settings_used = 0;

	// Handshake pacing state.
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int quiet_cycles = 0;
	bit seg_taken;
	res_beat_t want_reply;

	initial begin
		for (int i = 0; i < WIN; i++) begin
			occupied[i] = 1'b0;
			held_len[i] = '0;
			held_hdl[i] = '0;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Sequence number of window position off (negative for the previous window)
	// counted from base, wrapped into the sequence space.
	function automatic int unsigned seq_at(input int unsigned base, input int off);
		int v;
		v = int'(base) + 2 * MOD + off * STRIDE;
		return v % MOD;
	endfunction

	function automatic res_beat_t ack_beat(input logic [KIND_W-1:0] k, input int unsigned ack);
		res_beat_t r;
		r = '0;
		r.kind = k;
		r.hdr_seq = cfg_own_seq;
		r.hdr_ack = SEQ_W'(ack);
		return r;
	endfunction

	// Applies one accepted segment to the predicted window and queues the result
	// beats that it should produce: an ack followed by any in-order deliveries, a
	// duplicate ack, a FIN ack, or nothing at all.
	task automatic absorb_segment(input seg_beat_t s);
		res_beat_t   replies [WIN+1];
		int          n;
		int          slot;
		int unsigned sq;
		int unsigned ln;
		sq = s.seg_seq;
		ln = s.seg_length;
		n = 0;
		slot = -1;
		case (s.cmd)
			CMD_OPEN: begin
				win_base = cfg_start_base % MOD;
				for (int i = 0; i < WIN; i++)
					occupied[i] = 1'b0;
				conn_closed = 1'b0;
			end
			CMD_FIN: begin
				// Answered even on a closed connection.
				replies[0] = ack_beat(KIND_FIN_ACK, (sq + 1) % MOD);
				n = 1;
				conn_closed = 1'b1;
			end
			CMD_DATA: begin
				if (!conn_closed) begin
					// Scanning downwards leaves the lowest matching slot.
					for (int i = WIN - 1; i >= 0; i--)
						if ((win_base + i * STRIDE) % MOD == sq)
							slot = i;
					if (slot >= 0 && occupied[slot]) begin
						replies[0] = ack_beat(KIND_DUP_ACK, (sq + ln) % MOD);
						n = 1;
					end else if (slot >= 0) begin
						occupied[slot] = 1'b1;
						held_len[slot] = s.seg_length;
						held_hdl[slot] = s.payload_handle;
						replies[0] = ack_beat(KIND_ACK, (sq + ln) % MOD);
						n = 1;
						// Hand over every in-order slot and slide the window past it.
						while (occupied[0]) begin
							replies[n] = '0;
							replies[n].kind = KIND_DELIVER;
							replies[n].out_handle = held_hdl[0];
							replies[n].out_length = held_len[0];
							n++;
							for (int i = 0; i < WIN - 1; i++) begin
								occupied[i] = occupied[i+1];
								held_len[i] = held_len[i+1];
								held_hdl[i] = held_hdl[i+1];
							end
							occupied[WIN-1] = 1'b0;
							held_len[WIN-1] = '0;
							held_hdl[WIN-1] = '0;
							win_base = (win_base + STRIDE) % MOD;
						end
					end else begin
						// A retransmission of something already delivered.
						for (int i = 0; i < WIN; i++)
							if (n == 0 && (win_base + MOD - ((WIN - i) * STRIDE) % MOD) % MOD == sq) begin
								replies[0] = ack_beat(KIND_DUP_ACK, (sq + ln) % MOD);
								n = 1;
							end
					end
				end
			end
			default: ;
		endcase
		if (n > 0)
			replies[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_replies.push_back(replies[i]);
	endtask

	// ------------------------------------------------------------------
	// Segment driver. It offers queued segments in bursts of random length
	// separated by random gaps, keeps a stalled beat steady, and feeds every
	// beat that the block takes into the predictor at the edge where it is
	// taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		seg_taken = arst_n && seg_valid && !seg_stall;
		if (seg_taken) begin
			absorb_segment(seg);
			segs_accepted++;
		end
		if (arst_n && seg_valid && seg_stall)
			input_blocked++;
		if (seg_valid && !seg_taken) begin
			// Beat still on offer: payload and valid stay as they are.
		end else if (gap_left > 0) begin
			gap_left--;
			seg_valid <= 1'b0;
		end else if (arst_n && segment_queue.size() > 0) begin
			seg <= segment_queue.pop_front();
			seg_valid <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			seg_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver. It stalls on a pattern that changes every so often:
	// never, now and then, or most of the time. When the stimulus asks for it,
	// it holds off completely for a long stretch so that the block backs up.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 2) == 0);
				default: res_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: each result beat taken is compared field by field with
	// the oldest outstanding prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding (kind %0d)",
					res.kind));
			end else begin
				want_reply = pending_replies.pop_front();
				replies_checked++;
				case (want_reply.kind)
					KIND_DELIVER: deliveries_seen++;
					KIND_DUP_ACK: dup_acks_seen++;
					KIND_FIN_ACK: fin_acks_seen++;
					default: ;
				endcase
				if (res.kind !== want_reply.kind)
					report_mismatch($sformatf("result %0d kind: got %0d, want %0d",
						replies_checked, res.kind, want_reply.kind));
				if (res.hdr_seq !== want_reply.hdr_seq)
					report_mismatch($sformatf("result %0d hdr_seq: got %0d, want %0d",
						replies_checked, res.hdr_seq, want_reply.hdr_seq));
				if (res.hdr_ack !== want_reply.hdr_ack)
					report_mismatch($sformatf("result %0d hdr_ack: got %0d, want %0d",
						replies_checked, res.hdr_ack, want_reply.hdr_ack));
				if (res.out_handle !== want_reply.out_handle)
					report_mismatch($sformatf("result %0d out_handle: got %0h, want %0h",
						replies_checked, res.out_handle, want_reply.out_handle));
				if (res.out_length !== want_reply.out_length)
					report_mismatch($sformatf("result %0d out_length: got %0d, want %0d",
						replies_checked, res.out_length, want_reply.out_length));
				if (res.last !== want_reply.last)
					report_mismatch($sformatf("result %0d last: got %b, want %b",
						replies_checked, res.last, want_reply.last));
			end
		end
	end

	// Watchdog: a long run of cycles in which nothing at all moves means a hang.
	always @(posedge clk) begin
		if (!arst_n || psel || (seg_valid && !seg_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timed out after %0d idle cycles with %0d results outstanding.",
				quiet_cycles, pending_replies.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic queue_segment(input logic [CMD_W-1:0] cmd, input int unsigned sq,
			input int unsigned ln, input int unsigned hdl);
		seg_beat_t b;
		b.cmd = cmd;
		b.seg_seq = SEQ_W'(sq);
		b.seg_length = LEN_W'(ln);
		b.payload_handle = FHDL_W'(hdl);
		segment_queue.push_back(b);
	endtask

	// Waits until every queued segment has been taken by the block.
	task automatic wait_sent;
		do @(negedge clk); while (segment_queue.size() != 0 || seg_valid);
	endtask

	// Waits until the block has taken everything and returned every result, then
	// lets it finish any segment that was going to produce nothing.
	task automatic wait_settled;
		do @(negedge clk);
		while (segment_queue.size() != 0 || seg_valid || pending_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle; pready is always high.
	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register with junk in the unused upper bits, then reads it back.
	task automatic program_register(input logic idx, input logic [SEQ_W-1:0] value);
		logic [31:0] rd;
		apb_access(1'b1, idx, ($urandom() & 32'hFFFF_8000) | {17'd0, value}, rd);
		if (idx == REG_START_BASE)
			cfg_start_base = value;
		else
			cfg_own_seq = value;
		apb_access(1'b0, idx, 32'd0, rd);
		if (rd !== {17'd0, value})
			report_mismatch($sformatf("register %0d read back %0h, want %0h", idx, rd, value));
	endtask

	task automatic apply_settings(input int unsigned sb, input int unsigned os);
		program_register(REG_START_BASE, SEQ_W'(sb));
		program_register(REG_OWN_SEQ, SEQ_W'(os));
		settings_used++;
	endtask

	function automatic int unsigned pick_length;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return STRIDE;
			2: return $urandom_range(STRIDE + 1, 1023);
			default: return $urandom_range(1, STRIDE - 1);
		endcase
	endfunction

	// Queues one batch built around the window as it will stand when the batch
	// starts. Most beats are data segments for the slots of the current window in
	// shuffled order, so that slots fill out of order and then drain in runs of
	// deliveries; the rest are retransmissions, strays, FINs, opens and junk.
	task automatic queue_batch(input int count, inout int tally);
		int unsigned base;
		int          order [WIN];
		int          used;
		int          j;
		int          tmp;
		int          r;
		used = 0;
		if (conn_closed || $urandom_range(0, 3) == 0) begin
			queue_segment(CMD_OPEN, $urandom_range(0, 32767), $urandom_range(0, 1023),
				$urandom_range(0, 65535));
			base = cfg_start_base % MOD;
			tally++;
		end else begin
			base = win_base;
		end
		for (int i = 0; i < WIN; i++)
			order[i] = i;
		for (int i = WIN - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_segment(CMD_DATA,
					seq_at(base, (used < WIN) ? order[used] : $urandom_range(0, WIN - 1)),
					pick_length(), $urandom_range(0, 65535));
				used++;
				tally++;
			end else if (r < 79) begin
				queue_segment(CMD_DATA, seq_at(base, -$urandom_range(1, WIN)), pick_length(),
					$urandom_range(0, 65535));
				tally++;
			end else if (r < 84) begin
				queue_segment(CMD_DATA, $urandom_range(0, 32767), pick_length(),
					$urandom_range(0, 65535));
			end else if (r < 89) begin
				// Just beyond the window, or between two slot positions.
				if ($urandom_range(0, 1) == 0)
					queue_segment(CMD_DATA, seq_at(base, $urandom_range(WIN, WIN + 6)),
						pick_length(), $urandom_range(0, 65535));
				else
					queue_segment(CMD_DATA, (seq_at(base, $urandom_range(0, WIN - 1)) +
						$urandom_range(1, STRIDE - 1)) % MOD, pick_length(),
						$urandom_range(0, 65535));
			end else if (r < 92) begin
				queue_segment(CMD_FIN, $urandom_range(0, 32767), $urandom_range(0, 1023),
					$urandom_range(0, 65535));
				tally++;
			end else if (r < 97) begin
				queue_segment(CMD_SPARE, $urandom_range(0, 32767), $urandom_range(0, 1023),
					$urandom_range(0, 65535));
			end else begin
				queue_segment(CMD_OPEN, $urandom_range(0, 32767), 0, 0);
				base = cfg_start_base % MOD;
				tally++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int unsigned b;
		int          tally;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, on a window that straddles the wrap of the sequence space.
		apply_settings(24000, 25600);
		b = 24000;
		queue_segment(CMD_DATA, 0, STRIDE, 16'hFFFF);         // data before any open: dropped
		queue_segment(CMD_FIN, 32767, 0, 0);                  // FIN on a closed connection
		queue_segment(CMD_SPARE, 100, 1, 1);                  // unused command: dropped
		queue_segment(CMD_OPEN, 0, 0, 0);
		queue_segment(CMD_DATA, seq_at(b, 1), 0, 16'h0000);   // out of order, zero length
		queue_segment(CMD_DATA, seq_at(b, 1), 7, 16'h1234);   // same slot again: duplicate
		queue_segment(CMD_DATA, seq_at(b, 3), 1023, 16'hFFFF);// ack number wraps
		queue_segment(CMD_DATA, seq_at(b, 0), STRIDE, 16'h00A5); // delivers two slots
		b = seq_at(b, 2);
		queue_segment(CMD_DATA, seq_at(b, -1), 100, 16'h5A5A); // previous window: duplicate
		queue_segment(CMD_DATA, MOD, 1, 1);                   // beyond the sequence space
		queue_segment(CMD_DATA, 32767, 1, 1);
		queue_segment(CMD_DATA, seq_at(b, WIN), 1, 1);        // one past the window
		queue_segment(CMD_DATA, (seq_at(b, 0) + 1) % MOD, 1, 1); // off the slot grid
		queue_segment(CMD_DATA, seq_at(b, 0), 300, 16'h8001); // delivers two slots
		b = seq_at(b, 2);
		// Fill the whole window from the top down; the last beat releases all of it.
		for (int k = WIN - 1; k >= 1; k--)
			queue_segment(CMD_DATA, seq_at(b, k), k * 50, $urandom_range(0, 65535));
		queue_segment(CMD_DATA, seq_at(b, 0), STRIDE, 16'hFFFF);
		queue_segment(CMD_FIN, MOD - 1, 0, 0);                // FIN ack wraps to zero

		// Random part: several register settings, the extremes among them, each
		// followed by batches until enough meaningful segments have gone in.
		for (int ph = 0; ph < 6; ph++) begin
			wait_settled();
			case (ph)
				0: apply_settings(0, 0);
				1: apply_settings(MOD - 1, 32767);
				2: apply_settings(32767, $urandom_range(0, 32767));
				3: apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767));
				4: apply_settings($urandom_range(MOD - 600, MOD - 1), 0);
				default: apply_settings($urandom_range(0, MOD - 1), MOD - 1);
			endcase
			// In two phases the receiver stops taking results for a long stretch
			// while the sender keeps offering, so the block has to back up.
			if (ph == 1 || ph == 4)
				hold_asks++;
			tally = 0;
			while (tally < 30) begin
				queue_batch($urandom_range(4, 14), tally);
				wait_sent();
			end
		end

		wait_settled();
		$display("Run covered %0d segment beats and %0d result beats over %0d register settings.",
			segs_accepted, replies_checked, settings_used);
		$display("Deliveries %0d, duplicate acks %0d, FIN acks %0d, input stalled %0d cycles.",
			deliveries_seen, dup_acks_seen, fin_acks_seen, input_blocked);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches.", mismatch_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/srrw_pkg.sv
rtl/srrw_cell.sv
rtl/srrw_ctrl.sv
rtl/selective_repeat_receive_window.sv
bench/selective_repeat_receive_window_tb.sv
